>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL. Each macro samples on the rising edge of clk
// and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JDS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/jds_pkg.sv
`timescale 1ns / 1ps

package jds_pkg;

    // Default size of the job table.
    localparam int JDS_MAX_JOBS = 8;

    // Configuration port address width (three registers at byte addresses 0, 4 and 8).
    localparam int PADDR_W = 4;

    // Field types.
    typedef logic [1:0]  opcode_t;
    typedef logic [2:0]  slot_t;
    typedef logic [15:0] arrival_t;
    typedef logic [11:0] burst_t;
    typedef logic [7:0]  prio_t;
    typedef logic [16:0] sclock_t;
    typedef logic [1:0]  mode_t;

    // Saturation value of the schedule clock.
    localparam sclock_t CLOCK_MAX = 17'h1FFFF;

    // Opcodes of the command channel.
    localparam opcode_t OP_LOAD     = 2'd0;
    localparam opcode_t OP_RESTART  = 2'd1;
    localparam opcode_t OP_DISPATCH = 2'd2;

    // Scheduling modes.
    localparam mode_t MODE_FCFS = 2'd0;
    localparam mode_t MODE_SJF  = 2'd1;
    localparam mode_t MODE_PRIO = 2'd2;
    localparam mode_t MODE_RR   = 2'd3;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_MODE    = 2'd0;
    localparam logic [1:0] REG_QUANTUM = 2'd1;
    localparam logic [1:0] REG_COUNT   = 2'd2;

    // Register reset values.
    localparam burst_t     QUANTUM_RESET = 12'd20;
    localparam logic [3:0] COUNT_RESET   = 4'd5;

    // One table entry as read by the scan.
    typedef struct packed {
        burst_t   rem;
        arrival_t arr;
        prio_t    prio;
    } job_entry_t;

    // Running result of one scan pass.
    typedef struct packed {
        logic     found;
        logic     any_pend;
        logic     any_arr;
        arrival_t min_arr;
        burst_t   best_rem;
        arrival_t best_arr;
        prio_t    best_prio;
    } scan_acc_t;

endpackage

>>> sv/jds_cmd_if.sv
`timescale 1ns / 1ps

interface jds_cmd_if import jds_pkg::*; ();
    logic     valid;
    logic     ready;
    opcode_t  opcode;
    slot_t    job_slot;
    arrival_t arrival_time;
    burst_t   burst_length;
    prio_t    job_priority;

    modport source (
        output valid, opcode, job_slot, arrival_time, burst_length, job_priority,
        input  ready
    );

    modport sink (
        input  valid, opcode, job_slot, arrival_time, burst_length, job_priority,
        output ready
    );
endinterface

>>> sv/jds_slice_if.sv
`timescale 1ns / 1ps

interface jds_slice_if import jds_pkg::*; ();
    logic    valid;
    logic    ready;
    slot_t   chosen_job;
    sclock_t start_time;
    burst_t  run_length;
    burst_t  remaining_after;
    logic    all_finished;

    modport source (
        output valid, chosen_job, start_time, run_length, remaining_after, all_finished,
        input  ready
    );

    modport sink (
        input  valid, chosen_job, start_time, run_length, remaining_after, all_finished,
        output ready
    );
endinterface

>>> sv/job_dispatch_scheduler.sv
`timescale 1ns / 1ps
// Job dispatch scheduler over a small job table (arrival, burst, priority per entry).
// Commands arrive on the cmd channel: load writes one entry, restart clears the clock
// and copies every burst into the remaining time, dispatch returns one slice on the
// slice channel. Loads and unused opcodes finish in the accept cycle and give nothing.
// Every transaction waits for valid and ready high at a rising clock edge.
// A restart sweeps all MAX_JOBS entries of the table, one entry a cycle.
// A dispatch walks the table through one registered read port and one compare unit,
// one entry a cycle, over the n active entries. First come mode makes one pass, as do
// shortest job and priority mode when some job has arrived; when none has arrived,
// or in round robin mode, a second pass follows, and round robin first brings the
// pointer below n by repeated subtraction of n.
// The command channel is ready only while the sequencer is idle, one command at a time.
// A finished slice sits in an output register; a stalled receiver does not block the
// next command, but a second slice waits until the first one is taken.
// Reset (rst_n low, asynchronous) empties the pending set, zeroes clock and pointer,
// and restores mode 0, quantum 20 and job count 5 on the APB-style register port.
module job_dispatch_scheduler import jds_pkg::*; #(
    parameter int MAX_JOBS = JDS_MAX_JOBS
) (
    input  logic               clk,
    input  logic               rst_n,
    jds_cmd_if.sink            cmd,
    jds_slice_if.source        slice,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    `include "assert_macros.svh"

    localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W = $clog2(MAX_JOBS + 1);

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_COPY  = 4'd1;
    localparam logic [3:0] S_MOD   = 4'd2;
    localparam logic [3:0] S_SCANA = 4'd3;
    localparam logic [3:0] S_DECA  = 4'd4;
    localparam logic [3:0] S_SCANB = 4'd5;
    localparam logic [3:0] S_RUN   = 4'd6;
    localparam logic [3:0] S_UPD   = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    // Configuration registers.
    mode_t      mode_reg;
    burst_t     quantum_reg;
    logic [3:0] count_reg;
    logic       cfg_we;

    // Sequencer and schedule state.
    logic [3:0]       state_reg, state_next;
    sclock_t          clock_reg, clock_next;
    logic [IDX_W-1:0] rr_reg, rr_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] base_reg, base_next;
    burst_t           run_reg, run_next;

    // Table walk.
    logic [CNT_W-1:0] iss_cnt_reg, iss_cnt_next;
    logic [IDX_W-1:0] iss_idx_reg, iss_idx_next;
    logic             dv_reg, dv_next;
    logic [IDX_W-1:0] didx_reg, didx_next;
    logic [CNT_W-1:0] lim, idx_inc;
    logic             scanning, issue, walk_done;

    // Pending result and output register.
    slot_t   res_job_reg, res_job_next;
    sclock_t res_start_reg, res_start_next;
    burst_t  res_run_reg, res_run_next;
    burst_t  res_rem_reg, res_rem_next;
    logic    res_fin_reg, res_fin_next;
    slot_t   out_job_reg;
    sclock_t out_start_reg;
    burst_t  out_run_reg;
    burst_t  out_rem_reg;
    logic    out_fin_reg;
    logic    out_vld_reg, out_load;

    // Table and scan unit connections.
    logic             cmd_acc, job_we, rem_arm, rem_we, scan_clr, scan_step, pend_only;
    logic [IDX_W-1:0] rem_waddr;
    burst_t           rem_wdata;
    arrival_t         rd_arr;
    burst_t           rd_burst, rd_rem;
    prio_t            rd_prio;
    job_entry_t       entry;
    scan_acc_t        acc;
    logic [IDX_W-1:0] best_idx;
    logic [CNT_W-1:0] active_n;
    logic [CNT_W-1:0] best_inc;
    burst_t           quantum_eff, rem_left;
    logic [17:0]      clock_sum;

    // Register port: writes in the access phase, reads from a mux.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_FCFS;
            quantum_reg <= QUANTUM_RESET;
            count_reg   <= COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (paddr[3:2])
                REG_MODE:    mode_reg    <= pwdata[1:0];
                REG_QUANTUM: quantum_reg <= pwdata[11:0];
                REG_COUNT:   count_reg   <= pwdata[3:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_MODE:    prdata = {30'd0, mode_reg};
            REG_QUANTUM: prdata = {20'd0, quantum_reg};
            REG_COUNT:   prdata = {28'd0, count_reg};
            default:     prdata = '0;
        endcase
    end

    // Command handshake.
    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_acc   = cmd.valid && cmd.ready;

    // Entries in use, limited to the table size.
    assign active_n = ({28'd0, count_reg} > 32'(MAX_JOBS)) ? CNT_W'(MAX_JOBS)
                                                          : CNT_W'(count_reg);

    // Walk bookkeeping shared by the copy sweep and both scan passes.
    assign scanning  = (state_reg == S_COPY) || (state_reg == S_SCANA)
                       || (state_reg == S_SCANB);
    assign lim       = (state_reg == S_COPY) ? CNT_W'(MAX_JOBS) : n_reg;
    assign issue     = scanning && (iss_cnt_reg < lim);
    assign walk_done = scanning && (iss_cnt_reg == lim) && dv_reg;
    assign idx_inc   = CNT_W'(iss_idx_reg) + CNT_W'(1);
    assign scan_step = dv_reg && ((state_reg == S_SCANA) || (state_reg == S_SCANB));
    assign pend_only = (state_reg == S_SCANA) && (mode_reg == MODE_FCFS);

    // Slice arithmetic.
    assign quantum_eff = (quantum_reg == '0) ? burst_t'(1) : quantum_reg;
    assign best_inc    = CNT_W'(best_idx) + CNT_W'(1);
    assign rem_left    = acc.best_rem - run_reg;
    assign clock_sum   = {1'b0, clock_reg} + {6'd0, run_reg};

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        clock_next     = clock_reg;
        rr_next        = rr_reg;
        n_next         = n_reg;
        base_next      = base_reg;
        run_next       = run_reg;
        iss_cnt_next   = iss_cnt_reg;
        iss_idx_next   = iss_idx_reg;
        dv_next        = 1'b0;
        didx_next      = didx_reg;
        res_job_next   = res_job_reg;
        res_start_next = res_start_reg;
        res_run_next   = res_run_reg;
        res_rem_next   = res_rem_reg;
        res_fin_next   = res_fin_reg;
        job_we         = 1'b0;
        rem_arm        = 1'b0;
        rem_we         = 1'b0;
        rem_waddr      = didx_reg;
        rem_wdata      = rd_burst;
        scan_clr       = 1'b0;
        out_load       = 1'b0;

        // Issue one table read per cycle while walking.
        if (issue)
        begin
            dv_next      = 1'b1;
            didx_next    = iss_idx_reg;
            iss_cnt_next = iss_cnt_reg + CNT_W'(1);
            iss_idx_next = (idx_inc == lim) ? '0 : IDX_W'(idx_inc);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_acc)
                begin
                    case (cmd.opcode)
                        OP_LOAD:
                        begin
                            job_we = ({29'd0, cmd.job_slot} < 32'(MAX_JOBS));
                        end
                        OP_RESTART:
                        begin
                            clock_next   = '0;
                            rr_next      = '0;
                            rem_arm      = 1'b1;
                            iss_cnt_next = '0;
                            iss_idx_next = '0;
                            state_next   = S_COPY;
                        end
                        OP_DISPATCH:
                        begin
                            n_next = active_n;
                            if (active_n == '0)
                            begin
                                res_job_next   = '0;
                                res_start_next = '0;
                                res_run_next   = '0;
                                res_rem_next   = '0;
                                res_fin_next   = 1'b1;
                                state_next     = S_EMIT;
                            end
                            else if (mode_reg == MODE_RR)
                            begin
                                base_next  = CNT_W'(rr_reg);
                                state_next = S_MOD;
                            end
                            else
                            begin
                                scan_clr     = 1'b1;
                                iss_cnt_next = '0;
                                iss_idx_next = '0;
                                state_next   = S_SCANA;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // Copy each burst into its remaining time, one entry a cycle.
            S_COPY:
            begin
                rem_we = dv_reg;
                if (walk_done)
                begin
                    state_next = S_IDLE;
                end
            end

            // Bring the round robin pointer below the active count.
            S_MOD:
            begin
                if (base_reg >= n_reg)
                begin
                    base_next = base_reg - n_reg;
                end
                else
                begin
                    scan_clr     = 1'b1;
                    iss_cnt_next = '0;
                    iss_idx_next = '0;
                    state_next   = S_SCANA;
                end
            end

            S_SCANA:
            begin
                if (walk_done)
                begin
                    state_next = S_DECA;
                end
            end

            // Decide after the first pass: jump the clock, finish, run the chosen job, or walk again.
            S_DECA:
            begin
                if (mode_reg == MODE_FCFS ? !acc.found : !acc.any_pend)
                begin
                    res_job_next   = '0;
                    res_start_next = '0;
                    res_run_next   = '0;
                    res_rem_next   = '0;
                    res_fin_next   = 1'b1;
                    state_next     = S_EMIT;
                end
                else if (mode_reg == MODE_FCFS)
                begin
                    if ({1'b0, acc.best_arr} > clock_reg)
                    begin
                        clock_next = {1'b0, acc.best_arr};
                    end
                    state_next = S_RUN;
                end
                else
                begin
                    if (!acc.any_arr)
                    begin
                        clock_next = {1'b0, acc.min_arr};
                    end
                    if (!acc.any_arr || (mode_reg == MODE_RR))
                    begin
                        scan_clr     = 1'b1;
                        iss_cnt_next = '0;
                        iss_idx_next = (mode_reg == MODE_RR) ? IDX_W'(base_reg) : '0;
                        state_next   = S_SCANB;
                    end
                    else
                    begin
                        state_next = S_RUN;
                    end
                end
            end

            S_SCANB:
            begin
                if (walk_done)
                begin
                    state_next = S_RUN;
                end
            end

            // Slice length and pointer advance.
            S_RUN:
            begin
                if ((mode_reg == MODE_RR) && (quantum_eff < acc.best_rem))
                begin
                    run_next = quantum_eff;
                end
                else
                begin
                    run_next = acc.best_rem;
                end
                if (mode_reg == MODE_RR)
                begin
                    rr_next = (best_inc == n_reg) ? '0 : IDX_W'(best_inc);
                end
                state_next = S_UPD;
            end

            // Write back the remaining time and advance the clock.
            S_UPD:
            begin
                rem_we         = 1'b1;
                rem_waddr      = best_idx;
                rem_wdata      = rem_left;
                res_job_next   = slot_t'(best_idx);
                res_start_next = clock_reg;
                res_run_next   = run_reg;
                res_rem_next   = rem_left;
                res_fin_next   = 1'b0;
                clock_next     = clock_sum[17] ? CLOCK_MAX : clock_sum[16:0];
                state_next     = S_EMIT;
            end

            // Hand the slice to the output register once it is free.
            S_EMIT:
            begin
                if (!out_vld_reg || slice.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            clock_reg   <= '0;
            rr_reg      <= '0;
            n_reg       <= '0;
            base_reg    <= '0;
            iss_cnt_reg <= '0;
            iss_idx_reg <= '0;
            dv_reg      <= 1'b0;
            didx_reg    <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clock_reg   <= clock_next;
            rr_reg      <= rr_next;
            n_reg       <= n_next;
            base_reg    <= base_next;
            iss_cnt_reg <= iss_cnt_next;
            iss_idx_reg <= iss_idx_next;
            dv_reg      <= dv_next;
            didx_reg    <= didx_next;
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (slice.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        run_reg       <= run_next;
        res_job_reg   <= res_job_next;
        res_start_reg <= res_start_next;
        res_run_reg   <= res_run_next;
        res_rem_reg   <= res_rem_next;
        res_fin_reg   <= res_fin_next;
        if (out_load)
        begin
            out_job_reg   <= res_job_reg;
            out_start_reg <= res_start_reg;
            out_run_reg   <= res_run_reg;
            out_rem_reg   <= res_rem_reg;
            out_fin_reg   <= res_fin_reg;
        end
    end

    assign slice.valid           = out_vld_reg;
    assign slice.chosen_job      = out_job_reg;
    assign slice.start_time      = out_start_reg;
    assign slice.run_length      = out_run_reg;
    assign slice.remaining_after = out_rem_reg;
    assign slice.all_finished    = out_fin_reg;

    // Job table storage.
    jds_table #(
        .MAX_JOBS (MAX_JOBS)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_we    (job_we),
        .job_waddr (IDX_W'(cmd.job_slot)),
        .job_arr   (cmd.arrival_time),
        .job_burst (cmd.burst_length),
        .job_prio  (cmd.job_priority),
        .rem_arm   (rem_arm),
        .rem_we    (rem_we),
        .rem_waddr (rem_waddr),
        .rem_wdata (rem_wdata),
        .rd_addr   (iss_idx_reg),
        .rd_arr    (rd_arr),
        .rd_burst  (rd_burst),
        .rd_prio   (rd_prio),
        .rd_rem    (rd_rem)
    );

    assign entry.rem  = rd_rem;
    assign entry.arr  = rd_arr;
    assign entry.prio = rd_prio;

    // Shared compare unit for both scan passes.
    jds_scan_unit #(
        .MAX_JOBS (MAX_JOBS)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .clr         (scan_clr),
        .step        (scan_step),
        .pend_only   (pend_only),
        .mode        (mode_reg),
        .sched_clock (clock_reg),
        .entry       (entry),
        .entry_idx   (didx_reg),
        .acc         (acc),
        .best_idx    (best_idx)
    );

    // The clock only moves backward on a restart.
    `JDS_ASSERT_NEXT(a_clock_forward, !(cmd_acc && (cmd.opcode == OP_RESTART)), clock_reg >= $past(clock_reg), "schedule clock moved backward")
    // Computing a slice always has a job in hand.
    `JDS_ASSERT_SAME(a_run_has_job, state_reg == S_RUN, acc.found, "slice computed without a chosen job")
    // The chosen job lies inside the active entries.
    `JDS_ASSERT_SAME(a_run_idx_range, state_reg == S_RUN, CNT_W'(best_idx) < n_reg, "chosen job outside the active entries")
    // After a round robin slice the pointer stays below the active count.
    `JDS_ASSERT_SAME(a_rr_in_range, (state_reg == S_UPD) && (mode_reg == MODE_RR), CNT_W'(rr_reg) < n_reg, "round robin pointer out of range")

endmodule

>>> sv/jds_table.sv
`timescale 1ns / 1ps

module jds_table import jds_pkg::*; #(
    parameter int MAX_JOBS = JDS_MAX_JOBS,
    localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_we,
    input  logic [IDX_W-1:0] job_waddr,
    input  arrival_t         job_arr,
    input  burst_t           job_burst,
    input  prio_t            job_prio,
    input  logic             rem_arm,
    input  logic             rem_we,
    input  logic [IDX_W-1:0] rem_waddr,
    input  burst_t           rem_wdata,
    input  logic [IDX_W-1:0] rd_addr,
    output arrival_t         rd_arr,
    output burst_t           rd_burst,
    output prio_t            rd_prio,
    output burst_t           rd_rem
);

    arrival_t arr_mem   [MAX_JOBS];
    burst_t   burst_mem [MAX_JOBS];
    prio_t    prio_mem  [MAX_JOBS];
    burst_t   rem_mem   [MAX_JOBS];

    burst_t rem_q_reg;
    logic   rem_live_reg;

    // Job table writes and the registered read port.
    always_ff @(posedge clk)
    begin
        if (job_we)
        begin
            arr_mem[job_waddr]   <= job_arr;
            burst_mem[job_waddr] <= job_burst;
            prio_mem[job_waddr]  <= job_prio;
        end
        if (rem_we)
        begin
            rem_mem[rem_waddr] <= rem_wdata;
        end
        rd_arr    <= arr_mem[rd_addr];
        rd_burst  <= burst_mem[rd_addr];
        rd_prio   <= prio_mem[rd_addr];
        rem_q_reg <= rem_mem[rd_addr];
    end

    // Remaining times read as zero until the first restart fills them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_live_reg <= 1'b0;
        end
        else if (rem_arm)
        begin
            rem_live_reg <= 1'b1;
        end
    end

    assign rd_rem = rem_live_reg ? rem_q_reg : '0;

endmodule

>>> sv/jds_scan_unit.sv
`timescale 1ns / 1ps

module jds_scan_unit import jds_pkg::*; #(
    parameter int MAX_JOBS = JDS_MAX_JOBS,
    localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clr,
    input  logic             step,
    input  logic             pend_only,
    input  mode_t            mode,
    input  sclock_t          sched_clock,
    input  job_entry_t       entry,
    input  logic [IDX_W-1:0] entry_idx,
    output scan_acc_t        acc,
    output logic [IDX_W-1:0] best_idx
);

    scan_acc_t        acc_reg, acc_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;

    logic pend, arrv, elig, better, replace;

    // Compare one entry against the best so far.
    always_comb
    begin
        pend    = (entry.rem != '0);
        arrv    = pend && ({1'b0, entry.arr} <= sched_clock);
        elig    = pend_only ? pend : arrv;
        better  = !acc_reg.found
                  || ((mode == MODE_SJF) && (entry.rem < acc_reg.best_rem))
                  || ((mode == MODE_PRIO) && (entry.prio > acc_reg.best_prio));
        replace = elig && better;

        acc_next      = acc_reg;
        best_idx_next = best_idx_reg;
        if (clr)
        begin
            acc_next = '0;
        end
        else if (step)
        begin
            acc_next.found    = acc_reg.found | elig;
            acc_next.any_pend = acc_reg.any_pend | pend;
            acc_next.any_arr  = acc_reg.any_arr | arrv;
            // Earliest pending arrival, the lower index wins a tie.
            if (pend && (!acc_reg.any_pend || (entry.arr < acc_reg.min_arr)))
            begin
                acc_next.min_arr = entry.arr;
            end
            if (replace)
            begin
                acc_next.best_rem  = entry.rem;
                acc_next.best_arr  = entry.arr;
                acc_next.best_prio = entry.prio;
                best_idx_next      = entry_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            best_idx_reg <= '0;
        end
        else
        begin
            acc_reg      <= acc_next;
            best_idx_reg <= best_idx_next;
        end
    end

    assign acc      = acc_reg;
    assign best_idx = best_idx_reg;

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import jds_pkg::*;

    localparam int MAX_JOBS      = JDS_MAX_JOBS;
    localparam int ITEM_TARGET   = 1500;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 4 * MAX_JOBS + 10;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_PHASE    = 5;
    localparam int DIR_ROWS      = 31;

    // The opcode that the block must ignore.
    localparam opcode_t OP_UNUSED = 2'd3;

    // One command transaction.
    typedef struct packed {
        opcode_t  op;
        slot_t    slot;
        arrival_t arrival;
        burst_t   burst;
        prio_t    prio;
    } cmd_t;

    // One slice transaction.
    typedef struct packed {
        slot_t   chosen;
        sclock_t start_at;
        burst_t  run_len;
        burst_t  left_after;
        logic    finished;
    } slice_t;

    // One row of the directed table: either a register write or a command.
    typedef struct packed {
        logic        is_reg;
        logic [1:0]  reg_idx;
        logic [11:0] reg_val;
        cmd_t        cmd;
        logic        typed;
        slice_t      want;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    jds_cmd_if   cmd_ch ();
    jds_slice_if slice_ch ();

    job_dispatch_scheduler u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .slice   (slice_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow of the job table, the schedule clock and the registers.
    arrival_t arrival_mem   [MAX_JOBS];
    burst_t   burst_mem     [MAX_JOBS];
    prio_t    prio_mem      [MAX_JOBS];
    burst_t   remaining_mem [MAX_JOBS];
    sclock_t  sched_now;
    int       rr_next;
    mode_t    cfg_mode;
    burst_t   cfg_quantum;
    logic [3:0] cfg_count;

    // Slices predicted but not yet seen on the output.
    slice_t slices_due [$];

    bit table_drained;
    bit hold_req;
    int tx_idle_pct;
    int rx_idle_pct;
    int error_count;
    int items_sent;
    int slices_checked;
    int cycle_count;

    dir_row_t dir_table [DIR_ROWS];

    always #5 clk = ~clk;

    // A job is eligible when it still needs time and its arrival has passed.
    function automatic bit job_arrived(input int i);
        return remaining_mem[i] != 0 && arrival_mem[i] <= sched_now;
    endfunction

    // Choose the next slice for the current mode and update the shadow state.
    function automatic slice_t pick_slice();
        slice_t s;
        int n, base, idx, pick;
        bit found, any_arrived, any_pending;
        arrival_t earliest;
        int unsigned run, quantum, sum;
        s = '0;
        found = 1'b0;
        pick = 0;
        any_arrived = 1'b0;
        any_pending = 1'b0;
        earliest = '0;
        n = (cfg_count > MAX_JOBS) ? MAX_JOBS : int'(cfg_count);
        if (cfg_mode == MODE_FCFS) begin
            for (int i = 0; i < n; i++) begin
                if (!found && remaining_mem[i] != 0) begin
                    pick = i;
                    found = 1'b1;
                end
            end
            if (found && arrival_mem[pick] > sched_now)
                sched_now = arrival_mem[pick];
        end else begin
            // With nothing eligible yet, the clock jumps to the earliest pending arrival.
            for (int i = 0; i < n; i++) begin
                if (job_arrived(i))
                    any_arrived = 1'b1;
                if (remaining_mem[i] != 0 && (!any_pending || arrival_mem[i] < earliest)) begin
                    earliest = arrival_mem[i];
                    any_pending = 1'b1;
                end
            end
            if (!any_arrived && any_pending)
                sched_now = earliest;
            if (any_pending) begin
                if (cfg_mode == MODE_RR) begin
                    base = rr_next % n;
                    for (int i = 0; i < n; i++) begin
                        idx = (base + i) % n;
                        if (!found && job_arrived(idx)) begin
                            pick = idx;
                            found = 1'b1;
                        end
                    end
                end else begin
                    for (int i = 0; i < n; i++) begin
                        if (job_arrived(i) && (!found ||
                            (cfg_mode == MODE_SJF && remaining_mem[i] < remaining_mem[pick]) ||
                            (cfg_mode == MODE_PRIO && prio_mem[i] > prio_mem[pick]))) begin
                            pick = i;
                            found = 1'b1;
                        end
                    end
                end
            end
        end
        if (!found) begin
            s.finished = 1'b1;
            return s;
        end
        run = remaining_mem[pick];
        if (cfg_mode == MODE_RR) begin
            quantum = (cfg_quantum == 0) ? 1 : cfg_quantum;
            if (quantum < run)
                run = quantum;
            rr_next = (pick + 1) % n;
        end
        remaining_mem[pick] = remaining_mem[pick] - burst_t'(run);
        s.chosen = slot_t'(pick);
        s.start_at = sched_now;
        s.run_len = burst_t'(run);
        s.left_after = remaining_mem[pick];
        sum = sched_now + run;
        sched_now = (sum > CLOCK_MAX) ? CLOCK_MAX : sclock_t'(sum);
        return s;
    endfunction

    // Apply one accepted command to the shadow state and queue its slice.
    task automatic track_command(input cmd_t c, input bit typed, input slice_t want);
        slice_t s;
        case (c.op)
            OP_LOAD:
            begin
                arrival_mem[c.slot] = c.arrival;
                burst_mem[c.slot] = c.burst;
                prio_mem[c.slot] = c.prio;
            end
            OP_RESTART:
            begin
                sched_now = '0;
                rr_next = 0;
                for (int i = 0; i < MAX_JOBS; i++)
                    remaining_mem[i] = burst_mem[i];
            end
            OP_DISPATCH:
            begin
                s = pick_slice();
                if (s.finished)
                    table_drained = 1'b1;
                slices_due.push_back(typed ? want : s);
            end
            default:
            begin
            end
        endcase
        if (c.op != OP_UNUSED)
            items_sent++;
    endtask

    // Offer one command and hold it until the block takes it.
    task automatic send_cmd(input cmd_t c, input bit typed, input slice_t want);
        @(negedge clk);
        cmd_ch.valid <= 1'b1;
        cmd_ch.opcode <= c.op;
        cmd_ch.job_slot <= c.slot;
        cmd_ch.arrival_time <= c.arrival;
        cmd_ch.burst_length <= c.burst;
        cmd_ch.job_priority <= c.prio;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        track_command(c, typed, want);
    endtask

    // Random idle burst on the command side.
    task automatic cmd_gap();
        int g;
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            g = $urandom_range(1, 17);
            @(negedge clk);
            cmd_ch.valid <= 1'b0;
            repeat (g - 1) @(negedge clk);
        end
    endtask

    // Wait until every predicted slice has arrived and the block has settled.
    task automatic wait_drained();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (slices_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle.
    task automatic write_reg(input logic [1:0] idx, input logic [11:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'({idx, 2'b00});
        pwdata <= {20'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_MODE:    cfg_mode = value[1:0];
            REG_QUANTUM: cfg_quantum = value;
            REG_COUNT:   cfg_count = value[3:0];
            default:     ;
        endcase
    endtask

    function automatic cmd_t cmd_of(input opcode_t op, input slot_t s, input arrival_t a,
                                    input burst_t b, input prio_t p);
        cmd_t c;
        c.op = op;
        c.slot = s;
        c.arrival = a;
        c.burst = b;
        c.prio = p;
        return c;
    endfunction

    // Command with every payload bit random, used for non-load and noise commands.
    function automatic cmd_t rand_cmd(input opcode_t op);
        return cmd_of(op, slot_t'($urandom), arrival_t'($urandom), burst_t'($urandom),
                      prio_t'($urandom));
    endfunction

    // Load with mostly small values, plus extremes, zero bursts and priority ties.
    function automatic cmd_t load_item(input slot_t s, input int unsigned arr_span,
                                       input int unsigned burst_span);
        cmd_t c;
        c = cmd_of(OP_LOAD, s, '0, '0, '0);
        case ($urandom_range(0, 15))
            0:       c.arrival = '1;
            1:       c.arrival = arrival_t'($urandom);
            default: c.arrival = arrival_t'($urandom_range(0, arr_span));
        endcase
        case ($urandom_range(0, 15))
            0:       c.burst = '0;
            1:       c.burst = burst_t'($urandom);
            2:       c.burst = '1;
            default: c.burst = burst_t'($urandom_range(1, burst_span));
        endcase
        case ($urandom_range(0, 15))
            0:       c.prio = '0;
            1:       c.prio = '1;
            2, 3:    c.prio = prio_t'($urandom);
            default: c.prio = prio_t'($urandom_range(1, 4));
        endcase
        return c;
    endfunction

    function automatic dir_row_t reg_row(input logic [1:0] idx, input logic [11:0] value);
        dir_row_t r;
        r = '0;
        r.is_reg = 1'b1;
        r.reg_idx = idx;
        r.reg_val = value;
        return r;
    endfunction

    function automatic dir_row_t cmd_row(input opcode_t op, input slot_t s, input arrival_t a,
                                         input burst_t b, input prio_t p);
        dir_row_t r;
        r = '0;
        r.cmd = cmd_of(op, s, a, b, p);
        return r;
    endfunction

    function automatic dir_row_t slice_row(input slot_t j, input sclock_t st, input burst_t run,
                                           input burst_t left);
        dir_row_t r;
        r = cmd_row(OP_DISPATCH, '0, '0, '0, '0);
        r.typed = 1'b1;
        r.want.chosen = j;
        r.want.start_at = st;
        r.want.run_len = run;
        r.want.left_after = left;
        return r;
    endfunction

    function automatic dir_row_t done_row();
        dir_row_t r;
        r = cmd_row(OP_DISPATCH, '0, '0, '0, '0);
        r.typed = 1'b1;
        r.want.finished = 1'b1;
        return r;
    endfunction

    // Report one field of a slice that differs from the prediction.
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Compare each slice transaction with the oldest prediction.
    always @(posedge clk) begin : slice_monitor
        slice_t got;
        slice_t want;
        if (rst_n && slice_ch.valid && slice_ch.ready) begin
            got.chosen = slice_ch.chosen_job;
            got.start_at = slice_ch.start_time;
            got.run_len = slice_ch.run_length;
            got.left_after = slice_ch.remaining_after;
            got.finished = slice_ch.all_finished;
            if (slices_due.size() == 0) begin
                $display("%0t ns: slice with no prediction waiting, expected none, actual %h",
                         $time, got);
                error_count++;
            end else begin
                want = slices_due.pop_front();
                check_field("chosen_job", want.chosen, got.chosen);
                check_field("start_time", want.start_at, got.start_at);
                check_field("run_length", want.run_len, got.run_len);
                check_field("remaining_after", want.left_after, got.left_after);
                check_field("all_finished", want.finished, got.finished);
            end
            slices_checked++;
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t ns: run did not finish in %0d cycles", $time, CYCLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Slice receiver: random stalls, one long hold-off on request.
    initial begin : slice_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        slice_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                slice_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                slice_ch.ready <= 1'b0;
            end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
                stall_left = $urandom_range(1, 17) - 1;
                slice_ch.ready <= 1'b0;
            end else begin
                slice_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int phase;
        int steps;
        int first_slot;
        int settings;
        int unsigned arr_span;
        int unsigned burst_span;
        logic [3:0] modes_seen;
        mode_t mode;
        burst_t quantum;
        logic [3:0] count;
        bit reload;
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.opcode = OP_LOAD;
        cmd_ch.job_slot = '0;
        cmd_ch.arrival_time = '0;
        cmd_ch.burst_length = '0;
        cmd_ch.job_priority = '0;
        for (int i = 0; i < MAX_JOBS; i++) begin
            arrival_mem[i] = '0;
            burst_mem[i] = '0;
            prio_mem[i] = '0;
            remaining_mem[i] = '0;
        end
        sched_now = '0;
        rr_next = 0;
        cfg_mode = MODE_FCFS;
        cfg_quantum = QUANTUM_RESET;
        cfg_count = COUNT_RESET;
        table_drained = 1'b0;
        hold_req = 1'b0;
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        error_count = 0;
        items_sent = 0;
        slices_checked = 0;
        cycle_count = 0;
        settings = 0;
        modes_seen = 4'b0001;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: empty table, every opcode, early starts, zero burst,
        // out-of-range job counts and the zero quantum.
        dir_table = '{
            done_row(),
            cmd_row(OP_UNUSED, 3'd5, 16'hFFFF, 12'hFFF, 8'hFF),
            cmd_row(OP_LOAD, 3'd0, 16'd10, 12'd5, 8'd3),
            cmd_row(OP_LOAD, 3'd1, 16'd0, 12'd4095, 8'd255),
            cmd_row(OP_LOAD, 3'd2, 16'd65535, 12'd1, 8'd1),
            cmd_row(OP_LOAD, 3'd3, 16'd0, 12'd0, 8'd0),
            cmd_row(OP_LOAD, 3'd4, 16'd3, 12'd7, 8'd255),
            cmd_row(OP_LOAD, 3'd5, 16'd100, 12'd2, 8'd9),
            cmd_row(OP_LOAD, 3'd6, 16'd100, 12'd2, 8'd9),
            cmd_row(OP_LOAD, 3'd7, 16'd65535, 12'd4095, 8'd128),
            cmd_row(OP_RESTART, 3'd0, 16'd0, 12'd0, 8'd0),
            slice_row(3'd0, 17'd10, 12'd5, 12'd0),
            slice_row(3'd1, 17'd15, 12'd4095, 12'd0),
            reg_row(REG_MODE, 12'(MODE_SJF)),
            cmd_row(OP_DISPATCH, 3'd0, 16'd0, 12'd0, 8'd0),
            cmd_row(OP_DISPATCH, 3'd0, 16'd0, 12'd0, 8'd0),
            done_row(),
            reg_row(REG_COUNT, 12'd0),
            cmd_row(OP_RESTART, 3'd0, 16'd0, 12'd0, 8'd0),
            done_row(),
            reg_row(REG_COUNT, 12'd15),
            reg_row(REG_QUANTUM, 12'd0),
            reg_row(REG_MODE, 12'(MODE_RR)),
            cmd_row(OP_RESTART, 3'd0, 16'd0, 12'd0, 8'd0),
            cmd_row(OP_DISPATCH, 3'd0, 16'd0, 12'd0, 8'd0),
            cmd_row(OP_DISPATCH, 3'd0, 16'd0, 12'd0, 8'd0),
            cmd_row(OP_DISPATCH, 3'd0, 16'd0, 12'd0, 8'd0),
            reg_row(REG_QUANTUM, 12'd4095),
            reg_row(REG_MODE, 12'(MODE_PRIO)),
            cmd_row(OP_DISPATCH, 3'd0, 16'd0, 12'd0, 8'd0),
            cmd_row(OP_DISPATCH, 3'd0, 16'd0, 12'd0, 8'd0)
        };
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_table[r].is_reg) begin
                wait_drained();
                write_reg(dir_table[r].reg_idx, dir_table[r].reg_val);
            end else begin
                send_cmd(dir_table[r].cmd, dir_table[r].typed, dir_table[r].want);
                cmd_gap();
            end
        end
        modes_seen = 4'b1111;

        // Random part: each phase picks a setting, fills the table, restarts,
        // and dispatches until the table is empty, with some noise mixed in.
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            phase++;
            wait_drained();
            mode = (phase <= 4) ? mode_t'(phase - 1) : mode_t'($urandom_range(0, 3));
            case ($urandom_range(0, 7))
                0:       quantum = '0;
                1:       quantum = 12'd1;
                2:       quantum = '1;
                3:       quantum = burst_t'($urandom);
                default: quantum = burst_t'($urandom_range(1, 30));
            endcase
            case ($urandom_range(0, 9))
                0:       count = 4'd0;
                1:       count = 4'($urandom_range(9, 15));
                2:       count = 4'd8;
                3:       count = 4'd1;
                default: count = 4'($urandom_range(2, 8));
            endcase
            if (phase == HOLD_PHASE) begin
                mode = MODE_FCFS;
                count = 4'd8;
            end
            write_reg(REG_MODE, 12'(mode));
            write_reg(REG_QUANTUM, quantum);
            write_reg(REG_COUNT, 12'(count));
            settings++;
            modes_seen[mode] = 1'b1;

            // Traffic shape for this phase; the closing stretch runs without idling.
            if (items_sent > ITEM_TARGET - 150) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else begin
                case ($urandom_range(0, 2))
                    0:       tx_idle_pct = 0;
                    1:       tx_idle_pct = 10;
                    default: tx_idle_pct = 35;
                endcase
                case ($urandom_range(0, 2))
                    0:       rx_idle_pct = 0;
                    1:       rx_idle_pct = 10;
                    default: rx_idle_pct = 35;
                endcase
            end
            case ($urandom_range(0, 3))
                0:       arr_span = 0;
                1:       arr_span = 30;
                2:       arr_span = 1000;
                default: arr_span = 65535;
            endcase
            case ($urandom_range(0, 2))
                0:       burst_span = 5;
                1:       burst_span = 60;
                default: burst_span = 300;
            endcase

            // Now and then keep the leftover remaining times from the last phase.
            reload = (phase == HOLD_PHASE) || ($urandom_range(0, 3) != 0);
            if (reload) begin
                first_slot = $urandom_range(0, MAX_JOBS - 1);
                for (int s = 0; s < MAX_JOBS; s++) begin
                    send_cmd(load_item(slot_t'((first_slot + s) % MAX_JOBS), arr_span,
                                       burst_span), 1'b0, '0);
                    cmd_gap();
                end
                send_cmd(rand_cmd(OP_RESTART), 1'b0, '0);
                cmd_gap();
            end
            if (phase == HOLD_PHASE)
                hold_req = 1'b1;

            table_drained = 1'b0;
            steps = 0;
            while (!table_drained && steps < 30) begin
                if ($urandom_range(0, 99) < 8)
                    send_cmd(rand_cmd(opcode_t'($urandom_range(0, 3))), 1'b0, '0);
                else
                    send_cmd(rand_cmd(OP_DISPATCH), 1'b0, '0);
                cmd_gap();
                steps++;
            end
        end

        // Drain and let the block settle before the verdict.
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (slices_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d commands over %0d random settings, checked %0d slices, modes %b.",
                 items_sent, settings, slices_checked, modes_seen);
        $display("Covered empty tables, late arrivals, zero bursts, count and quantum extremes, %s",
                 "and a long output stall.");
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
